// File: sv/lhm_pkg.sv
`timescale 1ns / 1ps

package lhm_pkg;

    // timestamp arithmetic width, elapsed time wraps modulo 2**TS_BITS
    localparam int TS_BITS        = 32;
    localparam int NOW_BITS       = 32;
    localparam int RTT_BITS       = 17;
    localparam int THR_BITS       = 16;
    localparam int LIMIT_BITS     = 8;
    localparam int HOLD_BITS      = 32;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CMP_BITS       = 64;

    localparam logic [THR_BITS-1:0]   DEF_SLOW_RTT      = THR_BITS'(800);
    localparam logic [LIMIT_BITS-1:0] DEF_TIMEOUT_LIMIT = LIMIT_BITS'(3);
    localparam logic [HOLD_BITS-1:0]  DEF_RECOVERY_HOLD = HOLD_BITS'(10000);
    localparam logic [LIMIT_BITS-1:0] TIMEOUT_MAX       = '1;
    localparam logic [RTT_BITS-1:0]   NO_SAMPLE         = '1;

    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_POOR    = 2'd1,
        ST_OFFLINE = 2'd2
    } link_state_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SLOW_RTT      = 2'd0,
        REG_TIMEOUT_LIMIT = 2'd1,
        REG_RECOVERY_HOLD = 2'd2,
        REG_DEGRADE_MODE  = 2'd3
    } cfg_index_t;

    // effective settings, zero already replaced by the defaults
    typedef struct packed {
        logic [THR_BITS-1:0]   slow_rtt;
        logic [LIMIT_BITS-1:0] timeout_limit;
        logic [HOLD_BITS-1:0]  recovery_hold;
        logic                  degrade_mode;
    } cfg_t;

    typedef struct packed {
        logic                kind;
        logic [RTT_BITS-1:0] rtt_ms;
        logic                round_last;
        logic [NOW_BITS-1:0] now_ms;
        logic                force_enable;
    } item_t;

endpackage

// File: sv/lhm_in_if.sv
`timescale 1ns / 1ps

interface lhm_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [16:0] rtt_ms;
    logic               round_last;
    logic [31:0]        now_ms;
    logic               force_enable;

    modport source (
        output valid, kind, rtt_ms, round_last, now_ms, force_enable,
        input  ready
    );
    modport sink (
        input  valid, kind, rtt_ms, round_last, now_ms, force_enable,
        output ready
    );
endinterface

// File: sv/lhm_out_if.sv
`timescale 1ns / 1ps

interface lhm_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] link_state;
    logic       state_changed;

    modport source (
        output valid, link_state, state_changed,
        input  ready
    );
    modport sink (
        input  valid, link_state, state_changed,
        output ready
    );
endinterface

// File: sv/lhm_cfg_regs.sv
`timescale 1ns / 1ps

module lhm_cfg_regs
    import lhm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [CFG_INDEX_BITS-1:0] wr_index,
    input  logic [CFG_DATA_BITS-1:0]  wr_data,
    output cfg_t                      cfg
);

    logic [THR_BITS-1:0]   thr_reg;
    logic [LIMIT_BITS-1:0] limit_reg;
    logic [HOLD_BITS-1:0]  hold_reg;
    logic                  degrade_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= DEF_SLOW_RTT;
            limit_reg   <= DEF_TIMEOUT_LIMIT;
            hold_reg    <= DEF_RECOVERY_HOLD;
            degrade_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                REG_SLOW_RTT:      thr_reg     <= wr_data[THR_BITS-1:0];
                REG_TIMEOUT_LIMIT: limit_reg   <= wr_data[LIMIT_BITS-1:0];
                REG_RECOVERY_HOLD: hold_reg    <= wr_data[HOLD_BITS-1:0];
                REG_DEGRADE_MODE:  degrade_reg <= wr_data[0];
                default:           thr_reg     <= thr_reg;
            endcase
        end
    end

    // zero in a register means the default value
    always_comb
    begin
        cfg.slow_rtt      = (thr_reg == '0) ? DEF_SLOW_RTT : thr_reg;
        cfg.timeout_limit = (limit_reg == '0) ? DEF_TIMEOUT_LIMIT : limit_reg;
        cfg.recovery_hold = (hold_reg == '0) ? DEF_RECOVERY_HOLD : hold_reg;
        cfg.degrade_mode  = degrade_reg;
    end

endmodule

// File: sv/lhm_input_stage.sv
`timescale 1ns / 1ps

module lhm_input_stage
    import lhm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    lhm_in_if.sink probe,
    input  logic   take,
    output logic   item_valid,
    output item_t  item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // slot frees up in the same cycle the core consumes it
    assign probe.ready = !valid_reg || take;
    assign valid_next  = (probe.valid && probe.ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (probe.valid && probe.ready)
        begin
            item_reg.kind         <= probe.kind;
            item_reg.rtt_ms       <= RTT_BITS'(probe.rtt_ms);
            item_reg.round_last   <= probe.round_last;
            item_reg.now_ms       <= probe.now_ms;
            item_reg.force_enable <= probe.force_enable;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: sv/lhm_core.sv
`timescale 1ns / 1ps

module lhm_core
    import lhm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      item_valid,
    input  item_t     item,
    output logic      take,
    lhm_out_if.source status
);

    link_state_t           state_reg, state_next;
    logic [LIMIT_BITS-1:0] tc_reg, tc_next, tc_inc;
    logic                  armed_reg, armed_next;
    logic [TS_BITS-1:0]    start_reg, start_next;
    logic                  forced_reg, forced_next;
    logic [RTT_BITS-1:0]   best_reg, best_next, best_acc;
    logic                  reach_reg, reach_next, reach_acc;

    logic                  sample_reach;
    logic [TS_BITS-1:0]    now_ts;
    logic [TS_BITS-1:0]    elapsed;

    logic                  res_valid_reg, res_valid_next;
    link_state_t           res_state_reg;
    logic                  res_changed_reg;

    assign take = item_valid && (!res_valid_reg || status.ready);

    always_comb
    begin
        state_next  = state_reg;
        tc_next     = tc_reg;
        armed_next  = armed_reg;
        start_next  = start_reg;
        forced_next = forced_reg;
        best_next   = best_reg;
        reach_next  = reach_reg;

        // negative rtt means the endpoint did not answer
        sample_reach = !item.rtt_ms[RTT_BITS-1];
        reach_acc    = reach_reg || sample_reach;
        best_acc     = (sample_reach && (item.rtt_ms < best_reg)) ? item.rtt_ms : best_reg;
        tc_inc       = (tc_reg == TIMEOUT_MAX) ? tc_reg : tc_reg + LIMIT_BITS'(1);
        now_ts       = TS_BITS'(item.now_ms);
        elapsed      = armed_reg ? (now_ts - start_reg) : '0;

        if (take)
        begin
            if (item.kind)
            begin
                if (forced_reg != item.force_enable)
                begin
                    forced_next = item.force_enable;
                    armed_next  = 1'b0;
                    if (item.force_enable)
                    begin
                        state_next = ST_OFFLINE;
                    end
                end
            end
            else if (!item.round_last)
            begin
                reach_next = reach_acc;
                best_next  = best_acc;
            end
            else
            begin
                reach_next = 1'b0;
                best_next  = NO_SAMPLE;
                if (forced_reg)
                begin
                    state_next = ST_OFFLINE;
                end
                else if (!reach_acc)
                begin
                    tc_next    = tc_inc;
                    armed_next = 1'b0;
                    if (tc_inc >= cfg.timeout_limit)
                    begin
                        state_next = ST_OFFLINE;
                    end
                end
                else
                begin
                    tc_next = '0;
                    if (best_acc > RTT_BITS'(cfg.slow_rtt))
                    begin
                        armed_next = 1'b0;
                        state_next = cfg.degrade_mode ? ST_OFFLINE : ST_POOR;
                    end
                    else if (state_reg != ST_GOOD)
                    begin
                        armed_next = 1'b1;
                        if (!armed_reg)
                        begin
                            start_next = now_ts;
                        end
                        if (CMP_BITS'(elapsed) >= CMP_BITS'(cfg.recovery_hold))
                        begin
                            state_next = ST_GOOD;
                        end
                    end
                end
            end
        end
    end

    assign res_valid_next = take ? 1'b1 : (status.ready ? 1'b0 : res_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_OFFLINE;
            tc_reg        <= '0;
            armed_reg     <= 1'b0;
            start_reg     <= '0;
            forced_reg    <= 1'b0;
            best_reg      <= NO_SAMPLE;
            reach_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tc_reg        <= tc_next;
            armed_reg     <= armed_next;
            start_reg     <= start_next;
            forced_reg    <= forced_next;
            best_reg      <= best_next;
            reach_reg     <= reach_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_state_reg   <= state_next;
            res_changed_reg <= (state_next != state_reg);
        end
    end

    assign status.valid         = res_valid_reg;
    assign status.link_state    = res_state_reg;
    assign status.state_changed = res_changed_reg;

endmodule

// File: sv/link_health_monitor.sv
`timescale 1ns / 1ps

// link health monitor: classifies a link as good (0), poor (1) or offline (2) from
// rounds of probe samples. each request on probe is either one endpoint rtt sample
// (kind 0, negative rtt means unreachable, round_last flags the end of a round) or a
// force-offline control (kind 1). every request yields exactly one request on status
// with the state after it and a changed flag. the block takes one request per clock:
// a request is captured in the input register at acceptance, and when the core takes
// it the state update and the result register load happen together, so status valid
// rises as the result register loads, and from then on status can be handshaken.
// throughput is one per cycle as long as status is taken; a stalled status
// holds the result register and, through it, the input register. the state after
// reset is offline. settings are written through wr_en, wr_index and wr_data (0 rtt
// threshold, 1 timeout limit, 2 recovery hold, 3 degrade mode) and take effect on the
// next request; write them only while no request is in flight. a zero threshold,
// limit or hold acts as its reset value (800, 3, 10000).
module link_health_monitor
    import lhm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    lhm_in_if.sink                    probe,
    lhm_out_if.source                 status,
    input  logic                      wr_en,
    input  logic [CFG_INDEX_BITS-1:0] wr_index,
    input  logic [CFG_DATA_BITS-1:0]  wr_data
);

    cfg_t  cfg;
    item_t item;
    logic  item_valid;
    logic  take;

    // settings, with zero mapped to defaults
    lhm_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    // input register, refills in the cycle it drains
    lhm_input_stage u_input_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .probe      (probe),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // round tracking, state machine and result register
    lhm_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .status     (status)
    );

endmodule

// File: tb/link_health_monitor_test.sv
`timescale 1ns / 1ps

// self-checking bench for the link health monitor
module link_health_monitor_test
    import lhm_pkg::*;
();

    // cycles without any handshake before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    // rtt of -1, endpoint did not answer
    localparam logic [RTT_BITS-1:0] RTT_LOST = '1;

    typedef struct {
        link_state_t state;
        logic        changed;
    } status_t;

    logic                      clk;
    logic                      rst_n;
    logic                      wr_en;
    logic [CFG_INDEX_BITS-1:0] wr_index;
    logic [CFG_DATA_BITS-1:0]  wr_data;

    lhm_in_if  probe ();
    lhm_out_if status ();

    link_health_monitor u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .probe    (probe),
        .status   (status),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #5 clk = ~clk;

    // requests waiting for the driver, and link states still owed by the block
    item_t   pending_q[$];
    status_t expected_q[$];

    // register copies, raw as written (zero is resolved at judgment time)
    logic [THR_BITS-1:0]   thr_reg;
    logic [LIMIT_BITS-1:0] limit_reg;
    logic [HOLD_BITS-1:0]  hold_reg;
    logic                  degrade_reg;

    // mirror of the block's link state
    link_state_t           link_now;
    logic [LIMIT_BITS-1:0] dead_rounds;
    logic                  hold_armed;
    logic [TS_BITS-1:0]    hold_start;
    logic                  pinned;
    logic [RTT_BITS-1:0]   round_min_rtt;
    logic                  any_reply;

    // handshake bookkeeping
    item_t       next_req;
    item_t       seen_req;
    status_t     want;
    logic        probe_took;
    logic        calm;
    int unsigned send_gap;
    int unsigned stall_left;
    int unsigned quiet_cycles;
    int unsigned sent_count;
    int unsigned result_count;
    int unsigned change_count;
    int unsigned mismatches;
    logic [NOW_BITS-1:0] clock_ms;

    // ------------------------------------------------------------------
    // link state prediction
    // ------------------------------------------------------------------

    // move the mirrored state, flag whether it actually changed
    function automatic logic enter_state(link_state_t next);
        if (link_now == next)
            return 1'b0;
        link_now = next;
        return 1'b1;
    endfunction

    // applies one accepted request to the mirror and returns the status it must produce
    function automatic status_t judge_request(item_t req);
        logic                  changed;
        logic [THR_BITS-1:0]   thr_eff;
        logic [LIMIT_BITS-1:0] limit_eff;
        logic [HOLD_BITS-1:0]  hold_eff;
        logic                  had_reply;
        logic [RTT_BITS-1:0]   round_best;
        logic [TS_BITS-1:0]    elapsed;
        status_t               res;

        changed   = 1'b0;
        // zero registers fall back to the reset defaults
        thr_eff   = (thr_reg != '0) ? thr_reg : DEF_SLOW_RTT;
        limit_eff = (limit_reg != '0) ? limit_reg : DEF_TIMEOUT_LIMIT;
        hold_eff  = (hold_reg != '0) ? hold_reg : DEF_RECOVERY_HOLD;

        if (req.kind)
        begin
            // force control: only a toggle of the force flag has any effect
            if (pinned != req.force_enable)
            begin
                pinned     = req.force_enable;
                hold_armed = 1'b0;
                if (req.force_enable)
                    changed = enter_state(ST_OFFLINE);
            end
        end
        else
        begin
            // sign bit set means the endpoint was unreachable
            if (!req.rtt_ms[RTT_BITS-1])
            begin
                any_reply = 1'b1;
                if (req.rtt_ms < round_min_rtt)
                    round_min_rtt = req.rtt_ms;
            end
            if (req.round_last)
            begin
                had_reply     = any_reply;
                round_best    = round_min_rtt;
                any_reply     = 1'b0;
                round_min_rtt = RTT_LOST;
                if (pinned)
                begin
                    // forced rounds leave counter and timer alone
                    changed = enter_state(ST_OFFLINE);
                end
                else if (!had_reply)
                begin
                    // all-timeout round, counter saturates
                    if (dead_rounds != TIMEOUT_MAX)
                        dead_rounds = dead_rounds + 1'b1;
                    hold_armed = 1'b0;
                    if (dead_rounds >= limit_eff)
                        changed = enter_state(ST_OFFLINE);
                end
                else
                begin
                    dead_rounds = '0;
                    if (round_best > {1'b0, thr_eff})
                    begin
                        hold_armed = 1'b0;
                        changed = enter_state(degrade_reg ? ST_OFFLINE : ST_POOR);
                    end
                    else if (link_now != ST_GOOD)
                    begin
                        // good round: start or continue the recovery hold
                        if (!hold_armed)
                        begin
                            hold_armed = 1'b1;
                            hold_start = req.now_ms;
                        end
                        elapsed = req.now_ms - hold_start;   // wraps with the timestamp
                        if (elapsed >= hold_eff)
                            changed = enter_state(ST_GOOD);
                    end
                end
            end
        end

        res.state   = link_now;
        res.changed = changed;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // idle length for either side: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // probe sample request, force flag is junk since the block ignores it
    task automatic add_sample(logic [RTT_BITS-1:0] rtt, logic last, logic [NOW_BITS-1:0] t_ms);
        item_t req;
        req.kind         = 1'b0;
        req.rtt_ms       = rtt;
        req.round_last   = last;
        req.now_ms       = t_ms;
        req.force_enable = 1'($urandom_range(0, 1));
        pending_q = {pending_q, req};
    endtask

    // force control request, sample fields are junk
    task automatic add_force(logic enable);
        item_t req;
        req.kind         = 1'b1;
        req.rtt_ms       = RTT_BITS'($urandom());
        req.round_last   = 1'($urandom_range(0, 1));
        req.now_ms       = $urandom();
        req.force_enable = enable;
        pending_q = {pending_q, req};
    endtask

    // rtt for one sample; mood picks a dead, good or mixed round
    function automatic logic [RTT_BITS-1:0] pick_rtt(int unsigned mood);
        int unsigned thr_eff;
        int unsigned r;
        int unsigned lo;
        int unsigned hi;
        thr_eff = (thr_reg != '0) ? thr_reg : DEF_SLOW_RTT;
        r = $urandom_range(0, 99);
        if (mood < 20)
            return RTT_LOST;
        if (mood < 65)
        begin
            if (r < 15)
                return RTT_LOST;
            return RTT_BITS'($urandom_range(0, thr_eff));
        end
        if (r < 15)
            return RTT_LOST;
        if (r < 40)
            return RTT_BITS'($urandom_range(0, 65535));
        if (r < 75)
        begin
            // straddle the threshold
            lo = (thr_eff > 2) ? thr_eff - 2 : 0;
            hi = (thr_eff + 2 > 65535) ? 65535 : thr_eff + 2;
            return RTT_BITS'($urandom_range(lo, hi));
        end
        hi = (2 * thr_eff > 65535) ? 65535 : 2 * thr_eff;
        return RTT_BITS'($urandom_range(0, hi));
    endfunction

    // well-formed rounds of one to four samples, with a sprinkle of force requests
    task automatic add_rounds(int unsigned count, int unsigned max_step);
        int unsigned left;
        int unsigned span;
        int unsigned mood;
        left = count;
        while (left > 0)
        begin
            if ($urandom_range(0, 99) < 4)
            begin
                add_force($urandom_range(0, 99) < 40);
                left--;
            end
            else
            begin
                span = $urandom_range(1, 4);
                mood = $urandom_range(0, 99);
                for (int i = 0; i < span && left > 0; i++)
                begin
                    clock_ms += $urandom_range(0, max_step);
                    // rare jump anywhere on the timestamp range
                    if ($urandom_range(0, 99) < 2)
                        clock_ms = $urandom();
                    add_sample(pick_rtt(mood), (i == span - 1) || (left == 1), clock_ms);
                    left--;
                end
            end
        end
    endtask

    // one register write, mirror updated on the write edge
    task automatic set_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
        case (idx)
            REG_SLOW_RTT:      thr_reg     = value[THR_BITS-1:0];
            REG_TIMEOUT_LIMIT: limit_reg   = value[LIMIT_BITS-1:0];
            REG_RECOVERY_HOLD: hold_reg    = value[HOLD_BITS-1:0];
            REG_DEGRADE_MODE:  degrade_reg = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [CFG_DATA_BITS-1:0] thr, logic [CFG_DATA_BITS-1:0] limit,
                              logic [CFG_DATA_BITS-1:0] hold, logic degrade);
        set_reg(REG_SLOW_RTT, thr);
        set_reg(REG_TIMEOUT_LIMIT, limit);
        set_reg(REG_RECOVERY_HOLD, hold);
        set_reg(REG_DEGRADE_MODE, CFG_DATA_BITS'(degrade));
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    // hold the sender until every request is in and every status is back
    task automatic drain();
        do
            @(posedge clk);
        while (pending_q.size() != 0 || probe.valid || expected_q.size() != 0);
        // input and result register pipeline, leave some margin before touching registers
        repeat (4) @(posedge clk);
    endtask

    task automatic report_mismatch(string msg);
        $display("ERROR %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // request driver: changes on the falling edge only
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        // a request still waiting for ready stays on the bus untouched
        if (!probe.valid || probe_took)
        begin
            if (send_gap != 0)
            begin
                probe.valid <= 1'b0;
                send_gap    <= send_gap - 1;
            end
            else if (pending_q.size() != 0)
            begin
                next_req = pending_q.pop_front();
                probe.valid        <= 1'b1;
                probe.kind         <= next_req.kind;
                probe.rtt_ms       <= next_req.rtt_ms;
                probe.round_last   <= next_req.round_last;
                probe.now_ms       <= next_req.now_ms;
                probe.force_enable <= next_req.force_enable;
                send_gap           <= pick_gap();
            end
            else
            begin
                probe.valid <= 1'b0;
            end
        end
    end

    // status back-pressure: ready drops for random stretches
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            status.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            status.ready <= 1'b1;
            stall_left   <= pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // monitor and watchdog: everything sampled on the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        probe_took <= probe.valid && probe.ready;
        quiet_cycles++;
        if (rst_n)
        begin
            // accepted request: predict its status right away
            if (probe.valid && probe.ready)
            begin
                seen_req.kind         = probe.kind;
                seen_req.rtt_ms       = probe.rtt_ms;
                seen_req.round_last   = probe.round_last;
                seen_req.now_ms       = probe.now_ms;
                seen_req.force_enable = probe.force_enable;
                expected_q = {expected_q, judge_request(seen_req)};
                sent_count++;
                quiet_cycles = 0;
            end
            // accepted status: compare with the oldest prediction
            if (status.valid && status.ready)
            begin
                result_count++;
                quiet_cycles = 0;
                if (status.state_changed)
                    change_count++;
                if (expected_q.size() == 0)
                begin
                    report_mismatch($sformatf("status with no request pending: state %0d changed %0b",
                                              status.link_state, status.state_changed));
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (status.link_state !== want.state)
                        report_mismatch($sformatf("status %0d: link_state %0d, want %0d",
                                                  result_count, status.link_state, want.state));
                    if (status.state_changed !== want.changed)
                        report_mismatch($sformatf("status %0d: state_changed %0b, want %0b",
                                                  result_count, status.state_changed, want.changed));
                end
            end
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // run sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        wr_en              = 1'b0;
        wr_index           = REG_SLOW_RTT;
        wr_data            = '0;
        probe.valid        = 1'b0;
        probe.kind         = 1'b0;
        probe.rtt_ms       = '0;
        probe.round_last   = 1'b0;
        probe.now_ms       = '0;
        probe.force_enable = 1'b0;
        status.ready       = 1'b0;
        probe_took         = 1'b0;
        calm               = 1'b0;
        send_gap           = 0;
        stall_left         = 0;
        quiet_cycles       = 0;
        sent_count         = 0;
        result_count       = 0;
        change_count       = 0;
        mismatches         = 0;
        clock_ms           = '0;

        // mirror starts at the reset values: defaults, offline, no round
        thr_reg       = DEF_SLOW_RTT;
        limit_reg     = DEF_TIMEOUT_LIMIT;
        hold_reg      = DEF_RECOVERY_HOLD;
        degrade_reg   = 1'b0;
        link_now      = ST_OFFLINE;
        dead_rounds   = '0;
        hold_armed    = 1'b0;
        hold_start    = '0;
        pinned        = 1'b0;
        round_min_rtt = RTT_LOST;
        any_reply     = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed walk through the state machine with reset defaults
        // good round from offline only arms the hold timer
        add_sample(RTT_BITS'(0), 1'b1, 32'd1000);
        // extremes inside one round, best equals the threshold, hold just met
        add_sample(RTT_BITS'(65535), 1'b0, 32'd5000);
        add_sample(RTT_LOST, 1'b0, 32'd6000);
        add_sample(RTT_BITS'(800), 1'b1, 32'd11000);
        // one over the threshold: poor
        add_sample(RTT_BITS'(801), 1'b1, 32'd11500);
        // three dead rounds reach the limit, a fourth changes nothing
        add_sample(RTT_LOST, 1'b1, 32'd12000);
        add_sample(RTT_LOST, 1'b1, 32'd13000);
        add_sample(RTT_LOST, 1'b1, 32'd14000);
        add_sample(RTT_LOST, 1'b1, 32'd15000);
        // force while already offline, then a repeated force
        add_force(1'b1);
        add_force(1'b1);
        // a good round while forced stays offline
        add_sample(RTT_BITS'(5), 1'b1, 32'd20000);
        // release, then recover over the full hold
        add_force(1'b0);
        add_force(1'b0);
        add_sample(RTT_BITS'(5), 1'b1, 32'd21000);
        add_sample(RTT_BITS'(5), 1'b1, 32'd31000);
        // force from good, release keeps offline and the next round only arms the hold timer
        add_force(1'b1);
        add_force(1'b0);
        add_sample(RTT_BITS'(7), 1'b0, 32'hFFFF_FFFF);
        add_sample(RTT_BITS'(5), 1'b1, 32'd32000);
        drain();

        // full-scale registers: nothing exceeds the threshold, and only a
        // timestamp one behind the hold start reaches the maximum hold
        set_config(32'd65535, 32'd255, 32'hFFFF_FFFF, 1'b1);
        add_sample(RTT_LOST, 1'b1, 32'd3);
        add_sample(RTT_BITS'(10), 1'b1, 32'd5);
        add_sample(RTT_BITS'(65535), 1'b1, 32'd4);
        // long dead run: offline at 255, counter saturates past it
        for (int i = 0; i < 262; i++)
            add_sample(RTT_LOST, 1'b1, NOW_BITS'(100 + i));
        clock_ms = $urandom();
        add_rounds(150, 2000);
        drain();

        // smallest registers: any rtt above 1 is poor, one dead round is enough
        set_config(32'd1, 32'd1, 32'd1, 1'b0);
        add_rounds(250, 4);
        drain();

        // zero registers behave as the defaults, degrade turns poor into offline
        set_config(32'd0, 32'd0, 32'd0, 1'b1);
        add_sample(RTT_BITS'(801), 1'b1, clock_ms);
        add_rounds(250, 1500);
        drain();

        // defaults again, no idling, timestamps run across the wrap
        calm = 1'b1;
        set_config(32'd800, 32'd3, 32'd10000, 1'b0);
        clock_ms = 32'hFFFF_F000;
        add_rounds(350, 1500);
        drain();
        calm = 1'b0;

        // tighter mid-range settings
        set_config(32'd300, 32'd2, 32'd2000, 1'b0);
        add_rounds(350, 300);
        drain();

        // random mid-range settings
        set_config($urandom_range(1, 2000), $urandom_range(1, 8),
                   $urandom_range(1, 20000), 1'($urandom_range(0, 1)));
        add_rounds(300, 3000);
        drain();

        // let any stray status show up before judging
        repeat (10) @(posedge clk);

        $display("run: %0d requests sent, %0d status results checked, %0d state changes seen",
                 sent_count, result_count, change_count);
        $display("run: seven register settings incl. zero and full scale, force, saturation, wrap");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
